/* sv/b64d_pkg.sv */
// Shared types, constants and the character map of the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] SYM_SKIP = 8'd255;
  localparam logic [6:0] SYM_PAD  = 7'd64;
  localparam logic [1:0] QUAD_LAST = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_PAD    = 2'd1,
    STATUS_INCOMPLETE = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       last_result;
  } b64d_out_t;

  // One queued job: up to three decoded bytes and an optional status result.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_status;
    status_code_t    status;
  } b64d_job_t;

  typedef struct packed {
    logic      push;
    b64d_job_t job;
  } b64d_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // Map an ASCII byte onto its 6-bit symbol, the pad symbol, or SYM_SKIP.
  function automatic logic [7:0] map_char(input logic [7:0] ch);
    logic [7:0] sym;
    sym = SYM_SKIP;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      sym = ch - 8'd65;
    end else if (ch >= 8'd97 && ch <= 8'd122) begin
      sym = ch - 8'd71;
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      sym = ch + 8'd4;
    end else if (ch == 8'd43) begin
      sym = 8'd62;
    end else if (ch == 8'd47) begin
      sym = 8'd63;
    end else if (ch == 8'd61) begin
      sym = {1'b0, SYM_PAD};
    end
    return sym;
  endfunction

endpackage

/* sv/b64d_front.sv */
// Front end: maps characters, collects quartets and builds output jobs.
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  b64d_in_t    in_data,
  output b64d_push_t  push
);

  logic [2:0][6:0] pend;
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic            perr;
  logic            perr_next;
  logic [7:0]      sym;
  logic            take;
  logic [6:0]      a, b, c, d;
  b64d_job_t       job;

  always_comb begin
    sym       = map_char(in_data.in_char);
    take      = !perr && (sym != SYM_SKIP);
    a         = pend[0];
    b         = pend[1];
    c         = pend[2];
    d         = sym[6:0];
    cnt_next  = cnt;
    perr_next = perr;
    job.bytes[0]   = {a[5:0], b[5:4]};
    job.bytes[1]   = {b[3:0], c[5:2]};
    job.bytes[2]   = {c[1:0], d[5:0]};
    job.nbytes     = 2'd0;
    job.has_status = in_data.end_of_input;
    job.status     = STATUS_OK;
    if (take) begin
      if (cnt != QUAD_LAST) begin
        cnt_next = cnt + 2'd1;
      end else begin
        cnt_next = 2'd0;
        if (a == SYM_PAD || b == SYM_PAD || (c == SYM_PAD && d != SYM_PAD)) begin
          perr_next = 1'b1;
        end else if (c == SYM_PAD) begin
          job.nbytes = 2'd1;
        end else if (d == SYM_PAD) begin
          job.nbytes = 2'd2;
        end else begin
          job.nbytes = 2'd3;
        end
      end
    end
    if (in_data.end_of_input) begin
      if (perr_next) begin
        job.status = STATUS_BAD_PAD;
      end else if (cnt_next != 2'd0) begin
        job.status = STATUS_INCOMPLETE;
      end
      // start a new run
      cnt_next  = 2'd0;
      perr_next = 1'b0;
    end
    push.job  = job;
    push.push = accept && (job.nbytes != 2'd0 || job.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      perr <= 1'b0;
    end else if (accept) begin
      cnt  <= cnt_next;
      perr <= perr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take && cnt != QUAD_LAST) begin
      pend[cnt] <= d;
    end
  end

endmodule

/* sv/b64d_queue.sv */
// Job queue between the front end and the result sequencer.
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  b64d_push_t  push,
  input  logic        pop,
  output b64d_job_t   head,
  output b64d_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_job_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/b64d_back.sv */
// Back end: walks each queued job and issues one result per cycle while out_stall is low.
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  b64d_job_t   head,
  input  b64d_qstat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output b64d_out_t   out_data
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load;
  logic       last_of_job;
  b64d_out_t  res;

  always_comb begin
    total       = {1'b0, head.nbytes} + {2'b00, head.has_status};
    last_of_job = ({1'b0, idx} + 3'd1) == total;
    load        = !stat.empty && (!out_valid || !out_stall);
    pop         = load && last_of_job;
    res         = '0;
    if (idx < head.nbytes) begin
      case (idx)
        2'd0:    res.out_byte = head.bytes[0];
        2'd1:    res.out_byte = head.bytes[1];
        default: res.out_byte = head.bytes[2];
      endcase
    end else begin
      res.is_status   = 1'b1;
      res.status_code = head.status;
      res.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= !stat.empty;
      end
      if (load) begin
        idx <= last_of_job ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* sv/base64_stream_decoder_top.sv */
// Top level of the streaming base64 decoder.
//
// Input channel (in_valid / in_stall / in_data): one ASCII character per
// transaction, with end_of_input marking the last character of a run.
// Characters outside the base64 alphabet are dropped; '=' is padding.
// Output channel (out_valid / out_stall / out_data): one result per
// transaction, either a decoded byte (is_status = 0) or the final status of
// a run (is_status = 1, last_result = 1, status_code ok / bad pad / incomplete).
//
// Throughput: one character per cycle while in_stall is low, one result per
// cycle at the output while out_stall is low. A quartet of four characters
// gives at most three bytes, so the stream runs at full rate; each end_of_input
// adds one status result. The front end decodes a completed quartet in the
// accepting cycle and writes a job into the queue; the back end loads one
// result of the head job per cycle into the output register while the
// receiver does not stall.
// Back pressure: when the receiver stalls, the output register holds its
// result; the queue fills and in_stall rises once it holds QUEUE_DEPTH jobs.
// Reset (rst, synchronous): clears the quartet count, the padding error,
// the queue and the output valid; a new run starts with the next character.
module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  b64d_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output b64d_out_t out_data
);

  b64d_push_t  push;
  b64d_job_t   head;
  b64d_qstat_t stat;
  logic        accept;
  logic        pop;

  // hold input while the job queue is full
  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sv/b64d_checker.sv */
// Port-level checker for the base64 stream decoder, bound to the top level.
module b64d_checker import b64d_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input b64d_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_status |-> out_data.last_result &&
      out_data.out_byte == 8'd0 && out_data.status_code != 2'd3)
    else $error("malformed status result");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_status |->
      !out_data.last_result && out_data.status_code == STATUS_OK)
    else $error("malformed data result");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_top.sv */
// Self-checking testbench for the streaming base64 decoder.
module tb_top;
  import b64d_pkg::*;

  localparam int RANDOM_ITEMS = 190;  // at least this many characters are sent in the random part
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the job queue
  localparam int DRAIN_EVERY  = 12;   // runs between full drains of the sender
  localparam int TAIL_CYCLES  = 12;   // settle time after the last expected result

  // One character to send, with its expected results typed in where they are obvious.
  typedef struct packed {
    logic [7:0]   ch;
    logic         eoi;
    logic         typed;
    logic [1:0]   nb;
    logic [23:0]  bytes;   // first byte in the top lane
    status_code_t st;
  } char_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_HEAVY, RX_TOGGLE} rx_mode_t;
  typedef enum logic [1:0] {RUN_CLEAN, RUN_SHORT, RUN_BADPAD, RUN_NOISE} run_kind_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  b64d_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  b64d_out_t out_data;

  // Decoder shadow state: held symbols, their count, the latched padding error.
  logic [6:0] held_sym [3];
  logic [1:0] held_cnt    = 2'd0;
  bit         pad_latched = 1'b0;

  b64d_out_t char_results [$];   // results of the character just decoded
  b64d_out_t due_results [$];    // results still owed by the block, oldest first

  int  fail_cnt    = 0;
  int  sent_items  = 0;
  int  burst_left  = 0;
  bit  hold_asked  = 1'b0;
  bit  hold_served = 1'b0;

  base64_stream_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Map an ASCII byte onto 0..63, the pad symbol, or the skip marker.
  function automatic logic [7:0] char_sym(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
    if (ch == "+") return 8'd62;
    if (ch == "/") return 8'd63;
    if (ch == "=") return {1'b0, SYM_PAD};
    return SYM_SKIP;
  endfunction

  // Inverse of the alphabet, for building encoded text.
  function automatic logic [7:0] sym_char(input int s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < 62) return 8'("0" + s - 52);
    if (s == 62) return "+";
    return "/";
  endfunction

  function automatic b64d_out_t data_res(input logic [7:0] b);
    return '{out_byte: b, is_status: 1'b0, status_code: STATUS_OK, last_result: 1'b0};
  endfunction

  function automatic b64d_out_t status_res(input status_code_t code);
    return '{out_byte: 8'h00, is_status: 1'b1, status_code: code, last_result: 1'b1};
  endfunction

  // Advance the shadow state by one character and collect its results.
  function automatic void decode_char(input logic [7:0] ch, input logic eoi);
    logic [7:0]   sym;
    logic [6:0]   a, b, c, d;
    status_code_t code;
    char_results.delete();
    sym = char_sym(ch);
    if (!pad_latched && sym != SYM_SKIP) begin
      if (held_cnt < QUAD_LAST) begin
        held_sym[held_cnt] = sym[6:0];
        held_cnt = held_cnt + 2'd1;
      end else begin
        a = held_sym[0];
        b = held_sym[1];
        c = held_sym[2];
        d = sym[6:0];
        held_cnt = 2'd0;
        if (a == SYM_PAD || b == SYM_PAD || (c == SYM_PAD && d != SYM_PAD)) begin
          pad_latched = 1'b1;
        end else begin
          char_results = {char_results, data_res({a[5:0], b[5:4]})};
          if (c != SYM_PAD) char_results = {char_results, data_res({b[3:0], c[5:2]})};
          if (d != SYM_PAD) char_results = {char_results, data_res({c[1:0], d[5:0]})};
        end
      end
    end
    if (eoi) begin
      if (pad_latched) code = STATUS_BAD_PAD;
      else if (held_cnt != 2'd0) code = STATUS_INCOMPLETE;
      else code = STATUS_OK;
      char_results = {char_results, status_res(code)};
      held_cnt = 2'd0;
      pad_latched = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic char_row_t char_row(input logic [7:0] ch, input logic eoi,
                                         input logic typed = 1'b0,
                                         input logic [1:0] nb = 2'd0,
                                         input logic [23:0] bytes = 24'h0,
                                         input status_code_t st = STATUS_OK);
    return '{ch: ch, eoi: eoi, typed: typed, nb: nb, bytes: bytes, st: st};
  endfunction

  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_sym(c) != SYM_SKIP);
    return c;
  endfunction

  // Offer one transaction, hold it until accepted, record what it owes, then pace.
  task automatic send_char(input char_row_t r);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{in_char: r.ch, end_of_input: r.eoi};
    do @(posedge clk); while (in_stall);
    decode_char(r.ch, r.eoi);
    if (r.typed) begin
      for (int i = 0; i < r.nb; i++)
        due_results = {due_results, data_res(r.bytes[23 - 8*i -: 8])};
      if (r.eoi) due_results = {due_results, status_res(r.st)};
    end else begin
      foreach (char_results[i]) due_results = {due_results, char_results[i]};
    end
    sent_items++;
    // Bursts of random length with random gaps; keep offering during the hold-off.
    if (!(hold_asked && !hold_served)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // One run of encoded text, mostly well formed, ending with end_of_input.
  task automatic send_run();
    logic [7:0] chars [$];
    run_kind_t  kind;
    int         pick, nquart, npad, pos;
    bit         tail_skip;
    pick = $urandom_range(0, 9);
    kind = (pick < 6) ? RUN_CLEAN : (pick == 6) ? RUN_SHORT : (pick < 9) ? RUN_BADPAD
                                                                         : RUN_NOISE;
    if (kind == RUN_NOISE) begin
      repeat ($urandom_range(1, 10)) chars = {chars, 8'($urandom_range(0, 255))};
    end else begin
      // mostly short runs, a few long ones
      nquart = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
      for (int q = 0; q < nquart; q++) begin
        // pads close the last quartet, and now and then one in mid-stream
        npad = (q == nquart - 1 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 0;
        for (int k = 0; k < 4; k++)
          chars = {chars, (k >= 4 - npad) ? "=" : sym_char($urandom_range(0, 63))};
      end
      if (kind == RUN_SHORT) begin
        repeat ($urandom_range(1, 3)) chars = {chars, sym_char($urandom_range(0, 63))};
      end else if (kind == RUN_BADPAD) begin
        // pad in the first, second, or third slot; a third-slot pad gets a symbol after it
        pos = 4 * $urandom_range(0, nquart - 1) + $urandom_range(0, 2);
        chars[pos] = "=";
        if (pos % 4 == 2) chars[pos + 1] = sym_char($urandom_range(0, 63));
      end
    end
    tail_skip = ($urandom_range(0, 5) == 0);
    foreach (chars[i]) begin
      if ($urandom_range(0, 7) == 0) send_char(char_row(skip_char(), 1'b0));
      send_char(char_row(chars[i], (i == chars.size() - 1) && !tail_skip));
    end
    if (tail_skip) send_char(char_row(skip_char(), 1'b1));
  endtask

  initial begin : stimulus
    char_row_t dir_rows [$];
    int        runs;
    dir_rows = {
      // empty run right after reset
      char_row(8'h00, 1'b1, 1'b1, 2'd0, 24'h0, STATUS_OK),
      // plain quartet
      char_row("T", 1'b0), char_row("W", 1'b0), char_row("F", 1'b0),
      char_row("u", 1'b0, 1'b1, 2'd3, 24'h4D616E),
      // all-ones quartet with a skipped byte inside, closing the run cleanly
      char_row("/", 1'b0), char_row("/", 1'b0), char_row(8'hFF, 1'b0), char_row("/", 1'b0),
      char_row("/", 1'b1, 1'b1, 2'd3, 24'hFFFFFF, STATUS_OK),
      // lone trailing symbol
      char_row("A", 1'b1, 1'b1, 2'd0, 24'h0, STATUS_INCOMPLETE),
      // one pad, then two pads mid-stream, decoding carries on
      char_row("Q", 1'b0), char_row("U", 1'b0), char_row("I", 1'b0),
      char_row("=", 1'b0, 1'b1, 2'd2, 24'h414200),
      char_row("A", 1'b0), char_row("A", 1'b0), char_row("=", 1'b0),
      char_row("=", 1'b0, 1'b1, 2'd1, 24'h000000),
      // third slot padded while the fourth is not
      char_row("A", 1'b0), char_row("B", 1'b0), char_row("=", 1'b0),
      char_row("C", 1'b1, 1'b1, 2'd0, 24'h0, STATUS_BAD_PAD),
      // four pads, then a symbol ignored under the latched error
      char_row("=", 1'b0), char_row("=", 1'b0), char_row("=", 1'b0), char_row("=", 1'b0),
      char_row("Z", 1'b1, 1'b1, 2'd0, 24'h0, STATUS_BAD_PAD)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_char(dir_rows[i]);
    drain();

    // Random runs; ask the receiver for a long hold-off while runs keep coming.
    sent_items = 0;
    runs       = 0;
    hold_asked = 1'b1;
    while (sent_items < RANDOM_ITEMS) begin
      send_run();
      runs++;
      if (runs % DRAIN_EVERY == 0) drain();
    end

    // Wait for every owed result, then give stray results time to show up.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_stall_pattern
    rx_mode_t mode;
    int       seg;
    @(posedge clk);
    forever begin
      if (hold_asked && !hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        seg  = $urandom_range(4, 40);
        repeat (seg) begin
          case (mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: each accepted result against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    b64d_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: out_byte %0h is_status %0b status_code %0d last_result %0b",
               out_data.out_byte, out_data.is_status, out_data.status_code,
               out_data.last_result);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
          fail_cnt++;
        end
        if (out_data.is_status !== want.is_status) begin
          $error("is_status: expected %0b, got %0b", want.is_status, out_data.is_status);
          fail_cnt++;
        end
        if (out_data.status_code !== want.status_code) begin
          $error("status_code: expected %0d, got %0d", want.status_code,
                 out_data.status_code);
          fail_cnt++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 out_data.last_result);
          fail_cnt++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_top.sv
sv/b64d_checker.sv
test/tb_top.sv
